// File: sv/dfg_pkg.sv
// ============================================================================
// dfg_pkg: shared constants for the distance falloff gain block
// Default widths and configuration register indexes.
// ============================================================================
`default_nettype none

package dfg_pkg;

  localparam int unsigned COORD_BITS_DEF     = 24;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 15;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ZONE_X       = 3'd0,
    CFG_ZONE_Y       = 3'd1,
    CFG_ZONE_Z       = 3'd2,
    CFG_INNER_RADIUS = 3'd3,
    CFG_OUTER_RADIUS = 3'd4
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: sv/dfg_if.sv
// ============================================================================
// dfg_if: channel interfaces of the distance falloff gain block
// Listener position input, gain result output and register write channel.
// ============================================================================
`default_nettype none

interface dfg_in_if #(
  parameter int unsigned COORD_BITS = dfg_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] listener_x;
  logic signed [COORD_BITS-1:0] listener_y;
  logic signed [COORD_BITS-1:0] listener_z;

  modport source (output valid, output listener_x, output listener_y,
                  output listener_z, input ready);
  modport sink   (input valid, input listener_x, input listener_y,
                  input listener_z, output ready);
endinterface

interface dfg_out_if #(
  parameter int unsigned COORD_BITS     = dfg_pkg::COORD_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = dfg_pkg::GAIN_FRAC_BITS_DEF
) ();
  logic                      valid;
  logic                      ready;
  logic [GAIN_FRAC_BITS:0]   influence;
  logic                      active;
  logic [COORD_BITS:0]       distance;

  modport source (output valid, output influence, output active,
                  output distance, input ready);
  modport sink   (input valid, input influence, input active,
                  input distance, output ready);
endinterface

interface dfg_cfg_if #(
  parameter int unsigned COORD_BITS = dfg_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [dfg_pkg::CFG_IDX_BITS-1:0]  index;
  logic [COORD_BITS-1:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/dfg_isqrt.sv
// ============================================================================
// dfg_isqrt: pipelined integer square root
// Digit-by-digit floor root, one result bit per register stage.
// ============================================================================
`default_nettype none

module dfg_isqrt #(
  parameter int unsigned IN_W = 2 * dfg_pkg::COORD_BITS_DEF + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     in_val,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   out_root
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned REM_W = OUT_W + 1;
  localparam int unsigned SH_W  = OUT_W + 3;

  logic             vld_r  [OUT_W];
  logic [REM_W-1:0] rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];
  logic [IN_W-1:0]  rad_r  [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rad_in;
    logic [SH_W-1:0]  sh;
    logic [SH_W-1:0]  trial;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;
    logic [OUT_W-1:0] root_nxt;
    logic [IN_W-1:0]  rad_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_val;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    // bring down the next bit pair and try the next root bit
    assign sh       = {rem_in, rad_in[IN_W-1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (sh >= trial);
    assign rem_nxt  = ge ? REM_W'(sh - trial) : REM_W'(sh);
    assign root_nxt = {root_in[OUT_W-2:0], ge};
    assign rad_nxt  = {rad_in[IN_W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= rad_nxt;
      end
    end
  end

  assign out_vld  = vld_r[OUT_W-1];
  assign out_root = root_r[OUT_W-1];

endmodule

`default_nettype wire

// File: sv/dfg_div.sv
// ============================================================================
// dfg_div: pipelined restoring divider
// Divides a numerator no larger than the divisor, shifted left by the
// quotient's fraction bits; one quotient bit per register stage.
// ============================================================================
`default_nettype none

module dfg_div #(
  parameter int unsigned NUM_W  = dfg_pkg::COORD_BITS_DEF - 1,
  parameter int unsigned Q_W    = dfg_pkg::GAIN_FRAC_BITS_DEF + 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [NUM_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [Q_W];
  logic [NUM_W-1:0]  rem_r  [Q_W];
  logic [NUM_W-1:0]  den_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              v_in;
    logic [NUM_W-1:0]  rem_in;
    logic [NUM_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [NUM_W:0]    sh;
    logic              ge;
    logic [NUM_W-1:0]  rem_nxt;

    if (k == 0) begin : g_first
      // top quotient bit: numerator compared unshifted
      assign v_in    = in_vld;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
      assign sh      = {1'b0, rem_in};
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
      assign sh      = {rem_in, 1'b0};
    end

    assign ge      = (sh >= {1'b0, den_in});
    assign rem_nxt = ge ? NUM_W'(sh - {1'b0, den_in}) : NUM_W'(sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        quo_r[k]  <= {quo_in[Q_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_quo  = quo_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

`default_nettype wire

// File: sv/distance_falloff_gain.sv
// ============================================================================
// distance_falloff_gain: linear distance attenuation of a spherical zone
// Measures listener-to-centre distance (floor integer root) and maps it to a
// Q1.15 influence that falls linearly from the inner to the outer radius.
// ============================================================================
//
//  channel   dir  handshake        payload
//  --------  ---  ---------------  ---------------------------------------
//  in_ch     in   valid / ready    listener_x, listener_y, listener_z
//  out_ch    out  valid / ready    influence, active, distance
//  cfg_ch    in   valid / ready    index, data (ready is always high)
//
//  One transaction enters per cycle unless the output holds the pipeline.
//  Data passes the front stages (difference, magnitude, square, sum), the
//  root pipeline (one root bit per stage), a compare stage, the divider
//  pipeline (one quotient bit per stage) and the output register.
//  Reset (synchronous, rst_n low) clears every stage valid bit and the zone
//  registers. A result not taken at the output freezes the whole pipeline and
//  drops in_ch.ready; nothing moves until out_ch.ready returns.
//
`default_nettype none

module distance_falloff_gain #(
  parameter int unsigned COORD_BITS     = dfg_pkg::COORD_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = dfg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  dfg_in_if.sink   in_ch,
  dfg_out_if.source out_ch,
  dfg_cfg_if.sink  cfg_ch
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;   // signed axis difference
  localparam int unsigned MAG_W  = COORD_BITS + 1;   // magnitude, below 2^C
  localparam int unsigned SQ_W   = 2 * MAG_W;        // one squared axis
  localparam int unsigned DIST_W = COORD_BITS + 1;   // root of the sum
  localparam int unsigned RAD_W  = COORD_BITS - 1;   // radius registers
  localparam int unsigned GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int unsigned AXES   = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

  typedef enum logic [1:0] {
    SEL_FULL,
    SEL_ZERO,
    SEL_DIV
  } gain_sel_t;

  typedef struct packed {
    gain_sel_t         sel;
    logic [DIST_W-1:0] root_dist;
  } div_side_t;

  // --------------------------------------------------------------------------
  // Zone registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] zone_r [AXES];
  logic [RAD_W-1:0]             inner_r;
  logic [RAD_W-1:0]             outer_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        zone_r[i] <= '0;
      end
      inner_r <= '0;
      outer_r <= '0;
    end else if (cfg_ch.valid) begin
      // indexes past the last register write nothing
      if (cfg_ch.index == dfg_pkg::CFG_ZONE_X) begin
        zone_r[0] <= cfg_ch.data;
      end
      if (cfg_ch.index == dfg_pkg::CFG_ZONE_Y) begin
        zone_r[1] <= cfg_ch.data;
      end
      if (cfg_ch.index == dfg_pkg::CFG_ZONE_Z) begin
        zone_r[2] <= cfg_ch.data;
      end
      if (cfg_ch.index == dfg_pkg::CFG_INNER_RADIUS) begin
        inner_r <= cfg_ch.data[RAD_W-1:0];
      end
      if (cfg_ch.index == dfg_pkg::CFG_OUTER_RADIUS) begin
        outer_r <= cfg_ch.data[RAD_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: hold everything while a result waits at the output
  // --------------------------------------------------------------------------
  logic out_vld_r;
  logic adv;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // Stages 1 to 3: difference, magnitude, square per axis
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] lis [AXES];
  logic signed [DIFF_W-1:0]     diff_r [AXES];
  logic [MAG_W-1:0]             mag_r  [AXES];
  logic [SQ_W-1:0]              sq_r   [AXES];
  logic                         s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [SQ_W-1:0]              sum_r;

  assign lis[0] = in_ch.listener_x;
  assign lis[1] = in_ch.listener_y;
  assign lis[2] = in_ch.listener_z;

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [DIFF_W-1:0] diff_nxt;
    logic signed [DIFF_W-1:0] neg;
    logic [MAG_W-1:0]         mag_nxt;

    assign diff_nxt = DIFF_W'(lis[a]) - DIFF_W'(zone_r[a]);
    assign neg      = -diff_r[a];
    assign mag_nxt  = diff_r[a][DIFF_W-1] ? $unsigned(neg) : $unsigned(diff_r[a]);

    always_ff @(posedge clk) begin
      if (adv) begin
        diff_r[a] <= diff_nxt;
        mag_r[a]  <= mag_nxt;
        sq_r[a]   <= mag_r[a] * mag_r[a];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: sum of squares (below 3 * 2^(2C), fits SQ_W bits)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // Root pipeline
  // --------------------------------------------------------------------------
  logic              rt_vld;
  logic [DIST_W-1:0] rt_dist;

  dfg_isqrt #(
    .IN_W (SQ_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s4_vld_r),
    .in_val   (sum_r),
    .out_vld  (rt_vld),
    .out_root (rt_dist)
  );

  // --------------------------------------------------------------------------
  // Compare stage: classify against the radii, prepare the division
  // --------------------------------------------------------------------------
  gain_sel_t        sel_nxt;
  logic             cmp_vld_r;
  div_side_t        cmp_side_r;
  logic [RAD_W-1:0] cmp_num_r;
  logic [RAD_W-1:0] cmp_den_r;

  always_comb begin
    priority if (rt_dist < DIST_W'(inner_r)) begin
      sel_nxt = SEL_FULL;
    end else if (rt_dist > DIST_W'(outer_r)) begin
      sel_nxt = SEL_ZERO;
    end else if (outer_r == inner_r) begin
      // zero span with distance on both radii: full influence
      sel_nxt = SEL_FULL;
    end else begin
      sel_nxt = SEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (adv) begin
      cmp_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmp_side_r.sel       <= sel_nxt;
      cmp_side_r.root_dist <= rt_dist;
      // only meaningful for SEL_DIV, where inner <= dist <= outer
      cmp_num_r            <= rt_dist[RAD_W-1:0] - inner_r;
      cmp_den_r            <= outer_r - inner_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline
  // --------------------------------------------------------------------------
  logic              dv_vld;
  logic [GAIN_W-1:0] dv_quo;
  div_side_t         dv_side;

  dfg_div #(
    .NUM_W  (RAD_W),
    .Q_W    (GAIN_W),
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (cmp_vld_r),
    .in_num   (cmp_num_r),
    .in_den   (cmp_den_r),
    .in_side  (cmp_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_nxt;
  logic [GAIN_W-1:0] influence_r;
  logic              active_r;
  logic [DIST_W-1:0] distance_r;

  always_comb begin
    unique case (dv_side.sel)
      SEL_FULL: gain_nxt = GAIN_ONE;
      SEL_ZERO: gain_nxt = '0;
      SEL_DIV:  gain_nxt = GAIN_ONE - dv_quo;
      default:  gain_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      influence_r <= gain_nxt;
      active_r    <= (gain_nxt != '0);
      distance_r  <= dv_side.root_dist;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.influence = influence_r;
  assign out_ch.active    = active_r;
  assign out_ch.distance  = distance_r;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ============================================================================
// testbench: regression for the distance falloff gain block
// Drives listener positions against a series of zone settings, predicts the
// distance, influence and active flag of every transaction, and compares each
// result in order, with random idling on both sides of the pipeline.
// ============================================================================

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB    = dfg_pkg::COORD_BITS_DEF;
  localparam int GF    = dfg_pkg::GAIN_FRAC_BITS_DEF;
  localparam int IDX_W = dfg_pkg::CFG_IDX_BITS;

  localparam longint unsigned GAIN_FULL  = 64'd1 << GF;
  localparam int unsigned     RADIUS_MAX = (1 << (CB - 1)) - 1;
  localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

  // Register indexes beyond the last real register: writes there land nowhere
  localparam logic [IDX_W-1:0] FIRST_SPARE_IDX =
      IDX_W'(dfg_pkg::CFG_OUTER_RADIUS + 1);
  localparam int unsigned SPARE_COUNT = (1 << IDX_W) - FIRST_SPARE_IDX;

  localparam int RESET_CYCLES   = 8;
  localparam int IDLE_PCT       = 9;
  localparam int DRAIN_CYCLES   = 60;      // pipeline is 47 deep at these widths
  localparam int SWEEP_PHASES   = 12;
  localparam int SWEEP_ITEMS    = 125;
  localparam int QUIET_PHASE    = 7;       // this phase runs with no idling
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [GF:0] influence;
    logic        active;
    logic [CB:0] distance;
  } gain_result_t;

  logic clk;
  logic rst_n;

  dfg_in_if  in_ch ();
  dfg_out_if out_ch ();
  dfg_cfg_if cfg_ch ();

  distance_falloff_gain dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the zone registers, updated on each accepted write
  logic signed [CB-1:0] centre_x, centre_y, centre_z;
  logic [CB-2:0]        full_radius, zero_radius;

  gain_result_t expected_gains[$];
  int           error_count  = 0;
  int           result_count = 0;
  int           cycle_count  = 0;
  bit           idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the pipeline never drains
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("distance_falloff_gain regression: fail");
      $finish;
    end
  end

  // Result side back-pressure: drop ready on roughly one cycle in eleven
  always @(posedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Squared distance along one axis, on sign-extended coordinates
  function automatic longint unsigned axis_sq(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
    longint da = a;
    longint db = b;
    longint d;
    d = da - db;
    return longint'(d * d);
  endfunction

  // Expected result for one listener position under the current zone setting
  function automatic gain_result_t predict_gain(input logic signed [CB-1:0] x,
                                                input logic signed [CB-1:0] y,
                                                input logic signed [CB-1:0] z);
    longint unsigned rem, root, probe, dlen, span, step, gain;
    gain_result_t    res;
    rem = axis_sq(x, centre_x) + axis_sq(y, centre_y) + axis_sq(z, centre_z);
    // Floor square root, one result bit per pass of the digit loop
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    dlen = root;
    // Linear falloff between the radii; an empty span counts as full
    if (dlen < full_radius) begin
      gain = GAIN_FULL;
    end else if (dlen > zero_radius) begin
      gain = 0;
    end else begin
      span = zero_radius - full_radius;
      if (span == 0) begin
        gain = GAIN_FULL;
      end else begin
        step = ((dlen - full_radius) << GF) / span;
        gain = GAIN_FULL - step;
      end
    end
    res.influence = gain[GF:0];
    res.active    = (gain != 0);
    res.distance  = dlen[CB:0];
    return res;
  endfunction

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    gain_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (expected_gains.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_count));
      end else begin
        want = expected_gains.pop_front();
        if (out_ch.influence !== want.influence)
          report_mismatch($sformatf("result %0d influence: expected %0d, got %0d",
                                    result_count, want.influence, out_ch.influence));
        if (out_ch.active !== want.active)
          report_mismatch($sformatf("result %0d active: expected %0d, got %0d",
                                    result_count, want.active, out_ch.active));
        if (out_ch.distance !== want.distance)
          report_mismatch($sformatf("result %0d distance: expected %0d, got %0d",
                                    result_count, want.distance, out_ch.distance));
      end
    end
  end

  // Offer one listener position and hold it until the transaction completes.
  // Valid stays high on return so back-to-back transactions need no gap.
  task automatic send_listener(input logic signed [CB-1:0] x,
                               input logic signed [CB-1:0] y,
                               input logic signed [CB-1:0] z);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.listener_x <= x;
    in_ch.listener_y <= y;
    in_ch.listener_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_gains.push_back(predict_gain(x, y, z));
  endtask

  task automatic stop_listener();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_gains.size() != 0) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can follow back to back
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [CB-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      dfg_pkg::CFG_ZONE_X:       centre_x    = data;
      dfg_pkg::CFG_ZONE_Y:       centre_y    = data;
      dfg_pkg::CFG_ZONE_Z:       centre_z    = data;
      dfg_pkg::CFG_INNER_RADIUS: full_radius = data[CB-2:0];
      dfg_pkg::CFG_OUTER_RADIUS: zero_radius = data[CB-2:0];
      default: ;
    endcase
  endtask

  // Reprogram the whole zone once the pipeline is empty. Radius data is the
  // full data width so the unused top bit can be exercised.
  task automatic program_zone(input logic signed [CB-1:0] x,
                              input logic signed [CB-1:0] y,
                              input logic signed [CB-1:0] z,
                              input logic [CB-1:0] inner,
                              input logic [CB-1:0] outer,
                              input bit with_spare);
    wait_idle();
    write_reg(dfg_pkg::CFG_ZONE_X, x);
    write_reg(dfg_pkg::CFG_ZONE_Y, y);
    write_reg(dfg_pkg::CFG_ZONE_Z, z);
    write_reg(dfg_pkg::CFG_INNER_RADIUS, inner);
    write_reg(dfg_pkg::CFG_OUTER_RADIUS, outer);
    if (with_spare)
      write_reg(IDX_W'(FIRST_SPARE_IDX + $urandom_range(SPARE_COUNT - 1)),
                CB'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  // Out of reset every register is zero: only the centre itself is in range
  task automatic test_reset_defaults();
    send_listener('0, '0, '0);
    send_listener(CB'(256), '0, '0);
    send_listener(COORD_MIN, COORD_MIN, COORD_MIN);
    send_listener(COORD_MAX, COORD_MAX, COORD_MAX);
    stop_listener();
  endtask

  // Radii of 2560 and 5120 around the origin: both edges and the slope
  task automatic test_boundaries();
    program_zone('0, '0, '0, CB'(2560), CB'(5120), 1'b0);
    send_listener('0, '0, '0);
    send_listener(CB'(2560), '0, '0);
    send_listener('0, CB'(2561), '0);
    send_listener('0, '0, CB'(3840));
    send_listener(-CB'(5119), '0, '0);
    send_listener(CB'(5120), '0, '0);
    send_listener('0, '0, -CB'(5121));
    send_listener(CB'(768), CB'(1024), '0);
    stop_listener();
  endtask

  // Inner radius above outer: full inside inner, nothing anywhere else
  task automatic test_inverted_radii();
    program_zone('0, '0, '0, CB'(5120), CB'(2560), 1'b0);
    send_listener(CB'(3000), '0, '0);
    send_listener('0, CB'(5120), '0);
    send_listener('0, '0, CB'(6000));
    stop_listener();
  endtask

  // Equal radii: a distance right on the shell gives full influence
  task automatic test_zero_span();
    program_zone(-CB'(1000), CB'(500), CB'(77), CB'(2560), CB'(2560), 1'b0);
    send_listener(-CB'(1000), CB'(500), CB'(77));
    send_listener(CB'(1560), CB'(500), CB'(77));
    send_listener(CB'(1561), CB'(500), CB'(77));
    stop_listener();
  endtask

  // Corner zones, widest distances, radius top bit set, spare index writes
  task automatic test_extremes();
    program_zone(COORD_MAX, COORD_MAX, COORD_MAX, '1, '1, 1'b1);
    send_listener(COORD_MAX, COORD_MAX, COORD_MAX);
    send_listener(COORD_MIN, COORD_MIN, COORD_MIN);
    send_listener(COORD_MIN, COORD_MAX, COORD_MAX);
    send_listener('0, COORD_MAX, COORD_MAX);
    stop_listener();
    program_zone(COORD_MIN, COORD_MIN, COORD_MIN, '0, CB'(RADIUS_MAX), 1'b1);
    send_listener(COORD_MAX, COORD_MAX, COORD_MAX);
    send_listener(COORD_MIN + CB'(1 << (CB - 2)), COORD_MIN, COORD_MIN);
    send_listener(COORD_MIN, COORD_MIN, COORD_MIN);
    stop_listener();
  endtask

  function automatic logic signed [CB-1:0] near_coord(
      input logic signed [CB-1:0] c, input int unsigned reach);
    int off;
    off = int'($urandom_range(2 * reach)) - int'(reach);
    return c + CB'(off);
  endfunction

  function automatic logic signed [CB-1:0] edge_coord();
    case ($urandom_range(5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '1;
      3: return '0;
      4: return CB'(1);
      default: return CB'($urandom());
    endcase
  endfunction

  // Random zone settings, each followed by a burst of listener positions.
  // Most positions land around the zone so the linear slope is well covered.
  task automatic test_random_sweep();
    int unsigned inner, outer, reach;
    logic signed [CB-1:0] zx, zy, zz;
    int pick;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      zx = CB'($urandom());
      zy = CB'($urandom());
      zz = CB'($urandom());
      case (phase % 6)
        0: begin
          inner = $urandom_range(1 << 16);
          outer = inner + 1 + $urandom_range(1 << 16);
        end
        1: begin
          inner = $urandom_range(RADIUS_MAX);
          outer = $urandom_range(RADIUS_MAX);
        end
        2: begin
          inner = $urandom_range(1 << 20);
          outer = inner;
        end
        3: begin
          outer = $urandom_range(1 << 18);
          inner = outer + 1 + $urandom_range(1 << 18);
        end
        4: begin
          inner = 0;
          outer = RADIUS_MAX;
        end
        default: begin
          zx    = edge_coord();
          zy    = edge_coord();
          zz    = edge_coord();
          inner = $urandom_range(1 << 12);
          outer = inner + $urandom_range(1 << 22);
        end
      endcase
      program_zone(zx, zy, zz, {1'($urandom()), inner[CB-2:0]},
                   {1'($urandom()), outer[CB-2:0]}, ($urandom_range(3) == 0));
      reach   = ((inner > outer) ? inner : outer) * 3 / 5 + 16;
      idle_on = (phase != QUIET_PHASE);
      for (int n = 0; n < SWEEP_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 60)
          send_listener(near_coord(centre_x, reach), near_coord(centre_y, reach),
                        near_coord(centre_z, reach));
        else if (pick < 85)
          send_listener(CB'($urandom()), CB'($urandom()), CB'($urandom()));
        else
          send_listener(edge_coord(), edge_coord(), edge_coord());
      end
      stop_listener();
      idle_on = 1'b1;
    end
  endtask

  initial begin
    // Hold every input at a known value through reset
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.listener_x <= '0;
    in_ch.listener_y <= '0;
    in_ch.listener_z <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= dfg_pkg::CFG_ZONE_X;
    cfg_ch.data      <= '0;
    centre_x    = '0;
    centre_y    = '0;
    centre_z    = '0;
    full_radius = '0;
    zero_radius = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_boundaries();
    test_inverted_radii();
    test_zero_span();
    test_extremes();
    test_random_sweep();

    // Drain the pipeline, then allow time for any stray result to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("distance_falloff_gain regression: pass");
    else
      $display("distance_falloff_gain regression: fail");
    $finish;
  end

endmodule

// File: sim.f
sv/dfg_pkg.sv
sv/dfg_if.sv
sv/dfg_isqrt.sv
sv/dfg_div.sv
sv/distance_falloff_gain.sv
verif/testbench.sv
